// File: hw/rtl/fsst_pkg.sv
// Shared types, constants and control structs for the Fibonacci search table unit.
package fsst_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int LEN_W          = 11;
    localparam int IDX_W          = 10;
    localparam int VAL_W          = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } rsp_t;

    typedef struct packed {
        logic write;
        logic start;
        logic grow;
        logic probe_rd;
        logic probe_cmp;
        logic fin_rd;
        logic fin_cmp;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic grow_more;
        logic probe_go;
        logic fin_go;
        logic rsp_busy;
    } dp_sts_t;

endpackage

// File: hw/rtl/fsst_datapath.sv
// Table memory, Fibonacci index registers, probe compare and result register.
module fsst_datapath #(
    parameter int DEPTH      = fsst_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fsst_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fsst_pkg::req_t                req,
    input  logic [fsst_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          cfg_we,
    input  fsst_pkg::dp_cmd_t             cmd,
    output fsst_pkg::dp_sts_t             sts,
    input  logic                          rsp_stall,
    output logic                          rsp_valid,
    output fsst_pkg::rsp_t                rsp
);
    import fsst_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = AW + 3;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [LEN_W-1:0]          len_reg;
    logic signed [SW-1:0]      n_reg, n_next;
    logic signed [SW-1:0]      f_reg, f1_reg, f2_reg;
    logic signed [SW-1:0]      offset_reg, i_reg, pos_reg;
    logic                      hit_reg;
    logic [DATA_WIDTH-1:0]     key_reg;
    logic                      rsp_valid_reg;
    rsp_t                      rsp_reg;

    logic [63:0]               val64;
    logic [DATA_WIDTH-1:0]     word;
    logic [31:0]               idx32, len32, n32, pos32;
    logic [AW-1:0]             wr_addr, rd_addr;
    logic signed [SW-1:0]      i_raw, i_clip, fin_idx;
    logic signed [DATA_WIDTH-1:0] e_s, k_s;

    always_comb
    begin
        val64   = {32'b0, req.value};
        word    = val64[DATA_WIDTH-1:0];
        idx32   = {{(32-IDX_W){1'b0}}, req.index};
        wr_addr = idx32[AW-1:0];
        len32   = {{(32-LEN_W){1'b0}}, len_reg};
        n32     = (len32 > 32'(DEPTH)) ? 32'(DEPTH) : len32;
        n_next  = SW'(n32);
        i_raw   = offset_reg + f2_reg;
        i_clip  = (i_raw > n_reg - SW'(1)) ? n_reg - SW'(1) : i_raw;
        fin_idx = offset_reg + SW'(1);
        rd_addr = cmd.fin_rd ? fin_idx[AW-1:0] : i_clip[AW-1:0];
        e_s     = rdata_reg;
        k_s     = key_reg;
        pos32   = 32'(pos_reg);
    end

    always_comb
    begin
        sts.grow_more = f_reg < n_reg;
        sts.probe_go  = (f_reg > SW'(1)) && !hit_reg && (i_clip >= 0);
        sts.fin_go    = !hit_reg && (f1_reg != 0) && (fin_idx < n_reg);
        sts.rsp_busy  = rsp_valid_reg && rsp_stall;
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (cmd.write && (idx32 < 32'(DEPTH)))
            mem[wr_addr] <= word;
        if (cmd.probe_rd || cmd.fin_rd)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else if (cfg_we)
            len_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg    <= word;
            n_reg      <= n_next;
            f2_reg     <= '0;
            f1_reg     <= SW'(1);
            f_reg      <= SW'(1);
            offset_reg <= -SW'(1);
            hit_reg    <= 1'b0;
            pos_reg    <= '0;
        end
        if (cmd.grow)
        begin
            f2_reg <= f1_reg;
            f1_reg <= f_reg;
            f_reg  <= f1_reg + f_reg;
        end
        if (cmd.probe_rd)
            i_reg <= i_clip;
        if (cmd.probe_cmp)
        begin
            if (e_s < k_s)
            begin
                f_reg      <= f1_reg;
                f1_reg     <= f2_reg;
                f2_reg     <= f1_reg - f2_reg;
                offset_reg <= i_reg;
            end
            else if (e_s > k_s)
            begin
                f_reg  <= f2_reg;
                f1_reg <= f1_reg - f2_reg;
                f2_reg <= f2_reg + f2_reg - f1_reg;
            end
            else
            begin
                hit_reg <= 1'b1;
                pos_reg <= i_reg;
            end
        end
        if (cmd.fin_cmp && (e_s == k_s))
        begin
            hit_reg <= 1'b1;
            pos_reg <= fin_idx;
        end
        if (cmd.emit)
        begin
            rsp_reg.found    <= hit_reg;
            rsp_reg.position <= hit_reg ? pos32[IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.found |-> rsp_reg.position == '0)
        else $error("not-found beat carries nonzero position");
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_rd |-> (i_clip >= 0) && (i_clip < n_reg))
        else $error("probe index outside used length");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(rsp_valid_reg && rsp_stall))
        else $error("result loaded over a stalled beat");
`endif

endmodule

// File: hw/rtl/fsst_ctrl.sv
// Sequencer for table writes and Fibonacci search steps.
module fsst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_stall,
    output fsst_pkg::dp_cmd_t cmd,
    input  fsst_pkg::dp_sts_t sts
);
    import fsst_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GROW   = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_FINCMP = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (req_op == OP_WRITE)
                        cmd.write = 1'b1;
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_GROW;
                    end
                end
            end
            ST_GROW:
            begin
                if (sts.grow_more)
                    cmd.grow = 1'b1;
                else
                    state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (sts.probe_go)
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = ST_CMP;
                end
                else
                    state_next = ST_FIN;
            end
            ST_CMP:
            begin
                cmd.probe_cmp = 1'b1;
                state_next    = ST_PROBE;
            end
            ST_FIN:
            begin
                if (sts.fin_go)
                begin
                    cmd.fin_rd = 1'b1;
                    state_next = ST_FINCMP;
                end
                else
                    state_next = ST_DONE;
            end
            ST_FINCMP:
            begin
                cmd.fin_cmp = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.rsp_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hw/rtl/fibonacci_search_sorted_table_unit.sv
// Top level: Fibonacci search over a sorted table of signed words.
// A write beat leaves the unit idle and ready for the next beat. A search beat runs its grow
// steps (15 for 1024 entries), then probes, each a registered read and a compare, then at most
// one final check, and loads its result when the result register is free; the next beat is
// taken in the cycle after that. One item at a time; result stalls keep the unit busy.
// Reset clears control, length and result valid; table contents stay undefined.
module fibonacci_search_sorted_table_unit #(
    parameter int DEPTH      = fsst_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fsst_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  fsst_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output fsst_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fsst_pkg::LEN_W-1:0] cfg_data
);
    import fsst_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    fsst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    fsst_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_data  (cfg_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// File: verif/fsst_search_checker.sv
// Checker for the Fibonacci search table unit: shadows the table, predicts answers, compares beats.
`timescale 1ns / 100ps

module fsst_search_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_stall,
    input  fsst_pkg::req_t             req,
    input  logic                       rsp_valid,
    input  logic                       rsp_stall,
    input  fsst_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [fsst_pkg::LEN_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         pending_results
);
    import fsst_pkg::*;

    logic signed [VAL_W-1:0] table_words [DEPTH_DEF];
    logic [LEN_W-1:0]        length_reg;
    rsp_t                    pending_answers [$];

    function automatic rsp_t fib_search(input logic signed [VAL_W-1:0] key);
        rsp_t answer;
        int   span;
        int   fib;
        int   fib_m1;
        int   fib_m2;
        int   offset;
        int   probe;
        logic hit;
        span = (int'(length_reg) > DEPTH_DEF) ? DEPTH_DEF : int'(length_reg);
        fib_m2 = 0;
        fib_m1 = 1;
        fib = 1;
        offset = -1;
        hit = 1'b0;
        answer = '0;
        while (fib < span)
        begin
            fib_m2 = fib_m1;
            fib_m1 = fib;
            fib = fib_m2 + fib_m1;
        end
        while (fib > 1 && !hit)
        begin
            probe = offset + fib_m2;
            if (probe > span - 1)
                probe = span - 1;
            if (table_words[probe] < key)
            begin
                fib = fib_m1;
                fib_m1 = fib_m2;
                fib_m2 = fib - fib_m1;
                offset = probe;
            end
            else if (table_words[probe] > key)
            begin
                fib = fib_m2;
                fib_m1 = fib_m1 - fib_m2;
                fib_m2 = fib - fib_m1;
            end
            else
            begin
                hit = 1'b1;
                answer.found = 1'b1;
                answer.position = IDX_W'(probe);
            end
        end
        if (!hit && fib_m1 != 0 && offset + 1 < span)
        begin
            if (table_words[offset + 1] == key)
            begin
                answer.found = 1'b1;
                answer.position = IDX_W'(offset + 1);
            end
        end
        return answer;
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_results = 0;
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            length_reg = '0;
            pending_answers.delete();
            pending_results = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                length_reg = cfg_data;
            if (req_valid && !req_stall)
            begin
                if (req.op == OP_WRITE)
                    table_words[req.index] = req.value;
                else
                    pending_answers.push_back(fib_search(req.value));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result beat with no search outstanding: found %0d position %0d",
                           rsp.found, rsp.position);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found mismatch: expected %0d, actual %0d", want.found, rsp.found);
                        mismatch_count++;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $error("position mismatch: expected %0d, actual %0d",
                               want.position, rsp.position);
                        mismatch_count++;
                    end
                end
            end
            pending_results = pending_answers.size();
        end
    end

endmodule

// File: verif/fibonacci_search_sorted_table_unit_tb.sv
// Testbench top for the Fibonacci search table unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module fibonacci_search_sorted_table_unit_tb;
    import fsst_pkg::*;

    localparam int DRAIN_CYCLES     = 64;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;

    localparam logic signed [VAL_W-1:0] WORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] WORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_stall;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;
    int               mismatch_count;
    int               pending_results;
    bit               quiet;
    bit               long_hold_req;

    logic signed [VAL_W-1:0] table_copy [DEPTH_DEF];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fibonacci_search_sorted_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    fsst_search_checker search_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val);
        req_t beat;
        int   gap;
        beat.op = op;
        beat.index = idx;
        beat.value = val;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_word(input int idx, input logic signed [VAL_W-1:0] val);
        table_copy[idx] = val;
        send_item(OP_WRITE, IDX_W'(idx), val);
    endtask

    task automatic search_for(input logic signed [VAL_W-1:0] key);
        send_item(OP_SEARCH, IDX_W'($urandom_range(0, DEPTH_DEF - 1)), key);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_length(input int len);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= LEN_W'(len);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_table(input int count, input bit ascending, input int max_step);
        longint                  level;
        logic signed [VAL_W-1:0] word;
        int                      i;
        if (count == DEPTH_DEF)
            level = longint'(WORD_MIN) + $urandom_range(0, 7);
        else
            level = longint'($signed($urandom));
        for (i = 0; i < count; i++)
        begin
            if (!ascending)
                word = $urandom;
            else if (level > longint'(WORD_MAX))
                word = WORD_MAX;
            else
                word = VAL_W'(level);
            write_word(i, word);
            if ($urandom_range(0, 15) != 0)
                level += $urandom_range(1, max_step);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_key(input int span);
        int sel;
        int pos;
        sel = $urandom_range(0, 9);
        pos = (span > 0) ? $urandom_range(0, span - 1) : 0;
        if (span > 0 && sel < 5)
            return table_copy[pos];
        if (span > 0 && sel < 7)
            return table_copy[pos] + ($urandom_range(0, 1) ? 1 : -1);
        if (sel < 9)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return -1;
            default: return 0;
        endcase
    endfunction

    task automatic search_burst(input int count, input int len);
        int span;
        int i;
        span = (len > DEPTH_DEF) ? DEPTH_DEF : len;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                write_word($urandom_range(0, DEPTH_DEF - 1), $urandom);
            search_for(pick_key(span));
        end
    endtask

    initial
    begin : result_sink
        int stall_cycles;
        bit hold_done;
        rsp_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            stall_cycles = quiet ? 0 : $urandom_range(0, 19);
            if (stall_cycles != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall))
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                           || (cfg_valid && cfg_ready)))
                idle_cycles++;
            else
                idle_cycles = 0;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int len;
        int full_lengths [4];
        full_lengths = '{1024, 2047, 1023, 1025};
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        search_for(WORD_MIN);
        write_word(0, WORD_MIN);
        write_word(1, -5);
        write_word(2, 7);
        write_word(3, WORD_MAX);
        write_word(DEPTH_DEF - 1, 0);
        set_length(4);
        search_for(WORD_MIN);
        search_for(-5);
        search_for(7);
        search_for(WORD_MAX);
        search_for(0);
        search_for(8);
        search_for(-6);
        set_length(1);
        search_for(WORD_MIN);
        search_for(7);
        set_length(2);
        search_for(-5);
        search_for(-4);
        write_word(0, 9);
        write_word(1, -3);
        write_word(2, 100);
        write_word(3, -50);
        set_length(4);
        search_for(-50);
        search_for(100);
        search_for(9);

        for (phase = 0; phase < 10; phase++)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            len = $urandom_range(1, 24);
            fill_table(len, phase != 3,
                       (phase % 3 == 0) ? 3 : ((phase % 3 == 1) ? 1000 : 16777215));
            set_length(len);
            if (phase == 5)
                long_hold_req = 1'b1;
            search_burst(10, len);
        end

        quiet = 1'b0;
        fill_table(DEPTH_DEF, 1'b1, 8388607);
        for (phase = 0; phase < 9; phase++)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            len = (phase < 4) ? full_lengths[phase] : $urandom_range(0, 2047);
            set_length(len);
            search_burst(8, len);
            if (phase == 2)
                settle();
            search_burst(8, len);
        end

        settle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fsst_pkg.sv
hw/rtl/fsst_datapath.sv
hw/rtl/fsst_ctrl.sv
hw/rtl/fibonacci_search_sorted_table_unit.sv
verif/fsst_search_checker.sv
verif/fibonacci_search_sorted_table_unit_tb.sv
